[rtl/spq_pkg.sv]
// spq_pkg: shared constants, types and step helpers of the scale pitch quantizer.
// Depends on nothing; used by every module of the block.
package spq_pkg;

   localparam int NOTE_W    = 7;
   localparam int NOTES     = 2 ** NOTE_W;
   localparam int PATTERN_W = 36;
   localparam int COUNT_W   = 4;
   localparam int IDX_W     = 4;
   localparam int STEP_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = PATTERN_W;

   localparam int REQ_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 4;

   localparam logic [7:0]          NOTE_LIMIT     = 8'd127;
   localparam logic [NOTE_W-1:0]   LOWEST_AUDIBLE = 7'd21;
   localparam logic [NOTE_W-1:0]   OCTAVE_NOTE    = 7'd12;
   localparam logic [STEP_W-1:0]   OCTAVE_STEP    = 4'd12;
   localparam logic [COUNT_W-1:0]  MAX_STEPS      = 4'd12;
   localparam int                  PATTERN_STEPS  = 12;

   localparam logic [NOTE_W-1:0]    BASE_NOTE_RESET    = 7'd0;
   localparam logic [COUNT_W-1:0]   STEP_COUNT_RESET   = 4'd7;
   localparam logic [PATTERN_W-1:0] STEP_PATTERN_RESET = 36'd336978;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_NOTE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PATTERN = 2'd2;

   // one write into the note table
   typedef struct packed {
      logic              en;
      logic [NOTE_W-1:0] addr;
      logic [NOTE_W-1:0] data;
   } tbl_wr_type;

   // interval of one step; codes outside 1 to 4 count as one semitone
   function automatic logic [STEP_W-1:0] step_size(logic [PATTERN_W-1:0] pattern,
                                                   logic [IDX_W-1:0] idx);
      logic [2:0] code;
      code = '0;
      for (int i = 0; i < PATTERN_STEPS; i++) begin
         if (idx == IDX_W'(i)) begin
            code = pattern[3*i +: 3];
         end
      end
      if (code >= 3'd1 && code <= 3'd4) begin
         return {1'b0, code};
      end
      return 4'd1;
   endfunction

   function automatic logic [STEP_W-1:0] next_step(logic [COUNT_W-1:0] count,
                                                   logic [PATTERN_W-1:0] pattern,
                                                   logic [IDX_W-1:0] idx);
      if (count == '0) begin
         return OCTAVE_STEP;
      end
      return step_size(pattern, idx);
   endfunction

   function automatic logic [IDX_W-1:0] next_idx(logic [COUNT_W-1:0] count,
                                                 logic [IDX_W-1:0] idx);
      logic [IDX_W:0] inc;
      inc = {1'b0, idx} + 1'b1;
      if (count == '0 || inc >= {1'b0, count}) begin
         return '0;
      end
      return inc[IDX_W-1:0];
   endfunction

endpackage

[rtl/spq_scale_builder.sv]
// spq_scale_builder: configuration registers and the sweep that fills the note table.
// Walks the scale once per configuration, writing the nearest scale note of every key.
// Depends on spq_pkg.
module spq_scale_builder
   import spq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output tbl_wr_type           tbl_wr,
   output logic                 busy
);

   typedef enum logic [2:0] {
      BLD_INIT  = 3'b001,
      BLD_FILL  = 3'b010,
      BLD_READY = 3'b100
   } bld_state_type;

   bld_state_type       state_ff, state_in;
   logic [NOTE_W-1:0]    base_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [PATTERN_W-1:0] pattern_ff;
   logic [7:0]           cur_ff, cur_in;
   logic [7:0]           nxt_ff, nxt_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [NOTE_W-1:0]    key_ff, key_in;

   logic [NOTE_W-1:0]    lowest;
   logic [COUNT_W-1:0]   count_eff;
   logic                 adv;
   logic [7:0]           a_note;
   logic [7:0]           b_note;
   logic                 b_valid;
   logic                 any_note;
   logic [8:0]           pair_sum;
   logic [8:0]           twice_key;
   logic [NOTE_W-1:0]    wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= BASE_NOTE_RESET;
         count_ff   <= STEP_COUNT_RESET;
         pattern_ff <= STEP_PATTERN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_NOTE:    base_ff    <= csr_wdata[NOTE_W-1:0];
            CSR_STEP_COUNT:   count_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_STEP_PATTERN: pattern_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // base raised by octaves until audible
   always_comb begin
      if (base_ff >= LOWEST_AUDIBLE) begin
         lowest = base_ff;
      end else if (base_ff + OCTAVE_NOTE >= LOWEST_AUDIBLE) begin
         lowest = base_ff + OCTAVE_NOTE;
      end else begin
         lowest = base_ff + OCTAVE_NOTE + OCTAVE_NOTE;
      end
      count_eff = (count_ff > MAX_STEPS) ? MAX_STEPS : count_ff;
   end

   always_comb begin
      adv      = (nxt_ff < NOTE_LIMIT) && ({1'b0, key_ff} == nxt_ff);
      a_note   = adv ? nxt_ff : cur_ff;
      b_note   = adv ? nxt_ff + {4'b0, next_step(count_eff, pattern_ff, idx_ff)} : nxt_ff;
      b_valid  = b_note < NOTE_LIMIT;
      any_note = cur_ff < NOTE_LIMIT;
      pair_sum  = {1'b0, a_note} + {1'b0, b_note};
      twice_key = {1'b0, key_ff, 1'b0};
      if (!any_note) begin
         wr_data = cur_ff[NOTE_W-1:0];
      end else if ({1'b0, key_ff} <= a_note || !b_valid) begin
         wr_data = a_note[NOTE_W-1:0];
      end else if (twice_key < pair_sum) begin
         wr_data = a_note[NOTE_W-1:0];
      end else begin
         wr_data = b_note[NOTE_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      nxt_in   = nxt_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      unique case (state_ff)
         BLD_INIT: begin
            cur_in   = {1'b0, lowest};
            nxt_in   = {1'b0, lowest} + {4'b0, next_step(count_eff, pattern_ff, '0)};
            idx_in   = next_idx(count_eff, '0);
            key_in   = '0;
            state_in = BLD_FILL;
         end
         BLD_FILL: begin
            cur_in = a_note;
            nxt_in = b_note;
            if (adv) begin
               idx_in = next_idx(count_eff, idx_ff);
            end
            key_in = key_ff + 1'b1;
            if (key_ff == NOTE_W'(NOTES - 1)) begin
               state_in = BLD_READY;
            end
         end
         BLD_READY: ;
         default: state_in = BLD_INIT;
      endcase
      // any register write rebuilds the table
      if (csr_we) begin
         state_in = BLD_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BLD_INIT;
      end else begin
         state_ff <= state_in;
      end
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
      idx_ff <= idx_in;
      key_ff <= key_in;
   end

   assign tbl_wr.en   = (state_ff == BLD_FILL);
   assign tbl_wr.addr = key_ff;
   assign tbl_wr.data = wr_data;
   assign busy        = (state_ff != BLD_READY);

endmodule

[rtl/spq_fifo.sv]
// spq_fifo: small first-in first-out queue built from registers.
// Used for the request queue and the result queue. Depends on spq_pkg.
module spq_fifo
   import spq_pkg::*;
#(
   parameter int WIDTH = NOTE_W,
   parameter int DEPTH = REQ_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

[rtl/spq_note_lookup.sv]
// spq_note_lookup: back end; holds the note table, reads it per request and
// queues results. Depends on spq_pkg and spq_fifo.
module spq_note_lookup
   import spq_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  tbl_wr_type        tbl_wr,
   input  logic              key_valid,
   input  logic [NOTE_W-1:0] key,
   output logic              key_take,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [NOTE_W-1:0] rsp_scale_note
);

   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   logic [NOTE_W-1:0] note_table_ff [NOTES];
   logic [NOTE_W-1:0] rd_data_ff;
   logic              inflight_ff;
   logic [CNT_W-1:0]  rsp_count;
   logic [CNT_W:0]    occupancy;

   // reserve a result slot for the read in flight
   assign occupancy = {1'b0, rsp_count} + {{CNT_W{1'b0}}, inflight_ff};
   assign key_take  = key_valid && (occupancy < (CNT_W+1)'(RSP_DEPTH));

   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         note_table_ff[tbl_wr.addr] <= tbl_wr.data;
      end
      if (key_take) begin
         rd_data_ff <= note_table_ff[key];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 1'b0;
      end else begin
         inflight_ff <= key_take;
      end
   end

   spq_fifo #(
      .WIDTH (NOTE_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (inflight_ff),
      .push_data (rd_data_ff),
      .pop       (rsp_pop),
      .pop_data  (rsp_scale_note),
      .full      (),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

endmodule

[rtl/scale_pitch_quantizer_core.sv]
// scale_pitch_quantizer_core: top level of the scale pitch quantizer.
// Depends on spq_pkg, spq_scale_builder, spq_fifo and spq_note_lookup.
//
// Usage:
//   Requests enter as queue pushes: req_key is taken at an edge with req_push high
//   and req_full low. Results leave as queue pops: rsp_scale_note is valid while
//   rsp_empty is low and is taken at an edge with rsp_pop high.
//   csr_we writes csr_wdata into register csr_index (0 base_note, 1 step_count,
//   2 step_pattern).
//   Every register write, and reset, starts a sweep that rebuilds a 128-entry
//   note table, one key per cycle; req_full stays high during it.
//   A request waits in the request queue, then in the registered table read
//   (rd_data_ff), before its result is pushed into the result queue.
//   Throughput is one request per cycle, set by the single table read port,
//   while no sweep runs. When the receiver stalls, up to RSP_DEPTH results wait
//   in the result queue and REQ_DEPTH requests in the request queue before
//   req_full rises. Reset empties both queues and restores register reset values.
module scale_pitch_quantizer_core
   import spq_pkg::*;
#(
   parameter int REQ_DEPTH = REQ_QUEUE_DEPTH,
   parameter int RSP_DEPTH = RSP_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [NOTE_W-1:0]    req_key,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [NOTE_W-1:0]    rsp_scale_note,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   tbl_wr_type        tbl_wr;
   logic              busy;
   logic              req_q_full;
   logic              req_q_empty;
   logic [NOTE_W-1:0] req_q_key;
   logic              key_take;

   assign req_full = req_q_full || busy;

   spq_scale_builder u_builder (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .tbl_wr    (tbl_wr),
      .busy      (busy)
   );

   spq_fifo #(
      .WIDTH (NOTE_W),
      .DEPTH (REQ_DEPTH)
   ) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !req_full),
      .push_data (req_key),
      .pop       (key_take),
      .pop_data  (req_q_key),
      .full      (req_q_full),
      .empty     (req_q_empty),
      .count     ()
   );

   spq_note_lookup #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_lookup (
      .clock          (clock),
      .reset          (reset),
      .tbl_wr         (tbl_wr),
      .key_valid      (!req_q_empty),
      .key            (req_q_key),
      .key_take       (key_take),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_scale_note (rsp_scale_note)
   );

endmodule

[sim/scale_pitch_quantizer_core_test.sv]
// scale_pitch_quantizer_core_test: self-checking bench for scale_pitch_quantizer_core.
// Depends on spq_pkg and the core; a queue-fed driver pushes keys, a monitor checks notes.
// Each note is checked against a local scale builder that runs on every accepted key.
module scale_pitch_quantizer_core_test
   import spq_pkg::*;
();

   localparam int CYCLE_LIMIT    = 300000;
   localparam int RANDOM_KEYS    = 550;
   localparam int RX_HOLD_CYCLES = 120;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_BURST     = 30;
   localparam int MAX_GAP        = 17;

   // no register behind this index
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      PLAN_KEY,
      PLAN_WRITE,
      PLAN_DRAIN,
      PLAN_HOLD
   } plan_kind_type;

   typedef struct {
      plan_kind_type         kind;
      logic [NOTE_W-1:0]     key;
      int                    gap;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_W-1:0]      data;
   } plan_entry_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [NOTE_W-1:0]    req_key = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [NOTE_W-1:0]    rsp_scale_note;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   plan_entry_type    request_plan[$];
   logic [NOTE_W-1:0] expected_notes[$];

   // register copies used for prediction
   logic [NOTE_W-1:0]    cfg_base = BASE_NOTE_RESET;
   logic [COUNT_W-1:0]   cfg_count = STEP_COUNT_RESET;
   logic [PATTERN_W-1:0] cfg_pattern = STEP_PATTERN_RESET;

   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_ticket = 0;

   // driver state
   plan_entry_type head;
   logic           offer;
   logic           fire;
   int             gap_left = 0;
   int             key_gap = 0;

   // monitor state
   logic [NOTE_W-1:0] want;
   int                pop_wait = 0;
   int                hold_left = 0;
   int                hold_seen = 0;
   int                notes_seen = 0;
   bit                rx_calm = 1'b0;

   // stimulus state
   int                   phase;
   int                   planned;
   int                   burst;
   bit                   calm;
   logic [PATTERN_W-1:0] odd_pattern;
   int                   odd_codes[12] = '{0, 5, 6, 7, 1, 2, 3, 4, 0, 7, 6, 5};

   scale_pitch_quantizer_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_key        (req_key),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_scale_note (rsp_scale_note),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[scale_pitch_quantizer_core] ERROR");
         $finish;
      end
   end

   // builds the scale from the register copies and snaps the key onto it
   function automatic logic [NOTE_W-1:0] quantize_key(logic [NOTE_W-1:0] key);
      logic [255:0] in_scale;
      logic [2:0]   code;
      int           lowest;
      int           highest;
      int           note;
      int           pos;
      int           span;
      int           d;
      in_scale = '0;
      span = (cfg_count > MAX_STEPS) ? int'(MAX_STEPS) : int'(cfg_count);
      lowest = cfg_base;
      while (lowest < LOWEST_AUDIBLE) begin
         lowest += OCTAVE_NOTE;
      end
      highest = lowest;
      note = lowest;
      pos = 0;
      while (note < NOTE_LIMIT) begin
         in_scale[note] = 1'b1;
         highest = note;
         if (span == 0) begin
            note += OCTAVE_NOTE;
         end else begin
            code = cfg_pattern[3*pos +: 3];
            // unknown codes move one semitone
            note += (code >= 3'd1 && code <= 3'd4) ? int'(code) : 1;
            pos++;
            if (pos >= span) begin
               pos = 0;
            end
         end
      end
      // empty scale gives the raised base
      if (lowest >= NOTE_LIMIT) begin
         return NOTE_W'(lowest);
      end
      if (key >= highest) begin
         return NOTE_W'(highest);
      end
      if (key <= lowest) begin
         return NOTE_W'(lowest);
      end
      // upper neighbor is tried first so ties round up
      for (d = 0; d < NOTES; d++) begin
         if (in_scale[key + d]) begin
            return NOTE_W'(key + d);
         end
         if (d <= key && in_scale[key - d]) begin
            return NOTE_W'(key - d);
         end
      end
      return NOTE_W'(highest);
   endfunction

   function automatic void apply_write(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] data);
      unique case (index)
         CSR_BASE_NOTE: begin
            cfg_base = data[NOTE_W-1:0];
         end
         CSR_STEP_COUNT: begin
            cfg_count = data[COUNT_W-1:0];
         end
         CSR_STEP_PATTERN: begin
            cfg_pattern = data[PATTERN_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   task automatic plan_key(logic [NOTE_W-1:0] key, int gap);
      plan_entry_type e;
      e.kind = PLAN_KEY;
      e.key = key;
      e.gap = gap;
      e.index = '0;
      e.data = '0;
      request_plan = {request_plan, e};
   endtask

   task automatic plan_write(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] data);
      plan_entry_type e;
      e.kind = PLAN_WRITE;
      e.key = '0;
      e.gap = 0;
      e.index = index;
      e.data = data;
      request_plan = {request_plan, e};
   endtask

   task automatic plan_marker(plan_kind_type kind);
      plan_entry_type e;
      e.kind = kind;
      e.key = '0;
      e.gap = 0;
      e.index = '0;
      e.data = '0;
      request_plan = {request_plan, e};
   endtask

   function automatic logic [NOTE_W-1:0] random_key();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         return '0;
      end
      if (pick == 1) begin
         return NOTE_W'(NOTES - 1);
      end
      return NOTE_W'($urandom_range(0, NOTES - 1));
   endfunction

   // new scale for the next phase; upper data bits carry noise
   task automatic plan_random_setup();
      logic [CSR_W-1:0] noise;
      int               pick;
      bit               wrote;
      wrote = 1'b0;
      noise = CSR_W'({$urandom, $urandom});
      if ($urandom_range(0, 2) != 0) begin
         pick = $urandom_range(0, 7);
         noise[NOTE_W-1:0] = (pick == 0) ? NOTE_W'(0) :
                             (pick == 1) ? NOTE_W'(NOTES - 1) :
                             NOTE_W'($urandom_range(0, NOTES - 1));
         plan_write(CSR_BASE_NOTE, noise);
         wrote = 1'b1;
      end
      noise = CSR_W'({$urandom, $urandom});
      if ($urandom_range(0, 2) != 0) begin
         pick = $urandom_range(0, 7);
         noise[COUNT_W-1:0] = (pick == 0) ? COUNT_W'(0) :
                              (pick == 1) ? MAX_STEPS :
                              (pick == 2) ? COUNT_W'($urandom_range(13, 15)) :
                              COUNT_W'($urandom_range(1, 12));
         plan_write(CSR_STEP_COUNT, noise);
         wrote = 1'b1;
      end
      if (!wrote || $urandom_range(0, 2) != 0) begin
         pick = $urandom_range(0, 5);
         noise = CSR_W'({$urandom, $urandom});
         if (pick == 0) begin
            noise = '0;
         end else if (pick == 1) begin
            noise = '1;
         end else if (pick < 4) begin
            // well-formed intervals only
            for (int i = 0; i < PATTERN_STEPS; i++) begin
               noise[3*i +: 3] = 3'($urandom_range(1, 4));
            end
         end
         plan_write(CSR_STEP_PATTERN, noise);
      end
   endtask

   // driver: offers keys from the plan, writes registers only while idle
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         csr_we <= 1'b0;
         gap_left = 0;
      end else begin
         offer = req_push && req_full;
         fire = 1'b0;
         if (req_push && !req_full) begin
            expected_notes = {expected_notes, quantize_key(req_key)};
            gap_left = key_gap;
         end
         if (!offer && request_plan.size() != 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               head = request_plan[0];
               case (head.kind)
                  PLAN_KEY: begin
                     offer = 1'b1;
                     req_key <= head.key;
                     key_gap = head.gap;
                     void'(request_plan.pop_front());
                  end
                  PLAN_WRITE: begin
                     // idle: all notes back and no table sweep running
                     if (expected_notes.size() == 0 && !req_full && !csr_we) begin
                        fire = 1'b1;
                        csr_index <= head.index;
                        csr_wdata <= head.data;
                        apply_write(head.index, head.data);
                        void'(request_plan.pop_front());
                     end
                  end
                  PLAN_DRAIN: begin
                     if (expected_notes.size() == 0) begin
                        void'(request_plan.pop_front());
                     end
                  end
                  PLAN_HOLD: begin
                     hold_ticket++;
                     void'(request_plan.pop_front());
                  end
                  default: begin
                     void'(request_plan.pop_front());
                  end
               endcase
            end
         end
         req_push <= offer;
         csr_we <= fire;
      end
   end

   // monitor: pops notes with random stalls and checks them in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_notes.size() == 0) begin
               $display("%0t: scale_note expected none, got %0d", $time, rsp_scale_note);
               mismatch_count++;
            end else begin
               want = expected_notes.pop_front();
               if (rsp_scale_note !== want) begin
                  $display("%0t: scale_note expected %0d, got %0d",
                           $time, want, rsp_scale_note);
                  mismatch_count++;
               end
            end
            notes_seen++;
            if (notes_seen % 40 == 0) begin
               rx_calm = ($urandom_range(0, 2) == 0);
            end
            pop_wait = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
         end
         // long hold-off lets the request side back up
         if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = RX_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (pop_wait > 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      odd_pattern = '0;
      for (int i = 0; i < PATTERN_STEPS; i++) begin
         odd_pattern[3*i +: 3] = 3'(odd_codes[i]);
      end

      // reset scale: major scale from note 24
      plan_key(7'd0, 0);
      plan_key(7'd127, 1);
      plan_key(7'd21, 0);
      plan_key(7'd20, 3);
      plan_key(7'd22, 0);
      plan_key(7'd126, 2);
      plan_write(CSR_UNUSED, CSR_W'({$urandom, $urandom}));
      plan_key(7'd64, 0);
      plan_key(7'd66, 0);

      // base 127 leaves no scale note below the limit
      plan_write(CSR_BASE_NOTE, CSR_W'(127));
      plan_write(CSR_STEP_COUNT, CSR_W'(0));
      plan_key(7'd0, 0);
      plan_key(7'd127, 0);
      plan_key(7'd60, 1);

      // octave steps from note 24; 27 and 26 lie nearest to 24
      plan_write(CSR_BASE_NOTE, CSR_W'(0));
      plan_key(7'd27, 0);
      plan_key(7'd26, 0);
      plan_key(7'd118, 2);
      plan_key(7'd117, 0);
      plan_key(7'd0, 0);

      // oversized count with unknown step codes
      plan_write(CSR_BASE_NOTE, CSR_W'(33));
      plan_write(CSR_STEP_COUNT, CSR_W'(15));
      plan_write(CSR_STEP_PATTERN, odd_pattern);
      plan_key(7'd34, 0);
      plan_key(7'd100, 0);
      plan_key(7'd126, 0);
      plan_key(7'd127, 0);

      // single unknown step from a base raised by one octave
      plan_write(CSR_BASE_NOTE, CSR_W'(20));
      plan_write(CSR_STEP_COUNT, CSR_W'(1));
      plan_write(CSR_STEP_PATTERN, '1);
      plan_key(7'd20, 0);
      plan_key(7'd127, 0);
      plan_key(7'd50, 0);

      phase = 0;
      planned = 0;
      while (planned < RANDOM_KEYS) begin
         plan_random_setup();
         calm = ($urandom_range(0, 2) == 0);
         burst = $urandom_range(15, 50);
         if (phase == 2 || phase == 9) begin
            plan_marker(PLAN_HOLD);
            for (int i = 0; i < HOLD_BURST; i++) begin
               plan_key(random_key(), 0);
            end
            planned += HOLD_BURST;
         end
         for (int i = 0; i < burst; i++) begin
            if (i == burst / 2 && (phase == 4 || $urandom_range(0, 3) == 0)) begin
               plan_marker(PLAN_DRAIN);
            end
            plan_key(random_key(), calm ? 0 : $urandom_range(0, MAX_GAP));
         end
         planned += burst;
         phase++;
      end

      @(negedge clock);
      while (request_plan.size() != 0 || req_push || expected_notes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_notes.size() == 0) begin
         $display("[scale_pitch_quantizer_core] OK");
      end else begin
         $display("[scale_pitch_quantizer_core] ERROR");
      end
      $finish;
   end

endmodule
